/* sv/mexp_pkg.sv */
package mexp_pkg;

  localparam int WIDTH_DEF = 64;
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_LOAD      = 3'd1,
    ACT_START_RED = 3'd2,
    ACT_START_RB  = 3'd3,
    ACT_START_BB  = 3'd4,
    ACT_OUTPUT    = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    WB_NONE    = 2'd0,
    WB_B       = 2'd1,
    WB_R       = 2'd2,
    WB_B_SHIFT = 2'd3
  } wb_t;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_IN     = 3'd2,
    C_Q_ONE     = 3'd3,
    C_BUSY      = 3'd4,
    C_E_ZERO    = 3'd5,
    C_E_BIT_CLR = 3'd6,
    C_OUT_FULL  = 3'd7
  } cond_t;

  typedef struct packed {
    act_t            act;
    wb_t             wb;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic q_one;
    logic busy;
    logic e_zero;
    logic e_bit;
    logic out_full;
  } status_t;

  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_TEST_Q    = 4'd1;
  localparam logic [PC_W-1:0] STEP_RED       = 4'd2;
  localparam logic [PC_W-1:0] STEP_RED_WAIT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_TEST_E    = 4'd4;
  localparam logic [PC_W-1:0] STEP_TEST_BIT  = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL       = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL_WAIT  = 4'd7;
  localparam logic [PC_W-1:0] STEP_SQR       = 4'd8;
  localparam logic [PC_W-1:0] STEP_SQR_WAIT  = 4'd9;
  localparam logic [PC_W-1:0] STEP_LOOP      = 4'd10;
  localparam logic [PC_W-1:0] STEP_OUT       = 4'd11;

  // The program: when the condition holds the step jumps to its target,
  // otherwise its action fires and the step counter advances.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{act: ACT_NONE, wb: WB_NONE, cond: C_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:     w = '{act: ACT_LOAD,      wb: WB_NONE,    cond: C_NO_IN,
                           target: STEP_IDLE};
      STEP_TEST_Q:   w = '{act: ACT_NONE,      wb: WB_NONE,    cond: C_Q_ONE,
                           target: STEP_OUT};
      STEP_RED:      w = '{act: ACT_START_RED, wb: WB_NONE,    cond: C_NEVER,
                           target: STEP_IDLE};
      STEP_RED_WAIT: w = '{act: ACT_NONE,      wb: WB_B,       cond: C_BUSY,
                           target: STEP_RED_WAIT};
      STEP_TEST_E:   w = '{act: ACT_NONE,      wb: WB_NONE,    cond: C_E_ZERO,
                           target: STEP_OUT};
      STEP_TEST_BIT: w = '{act: ACT_NONE,      wb: WB_NONE,    cond: C_E_BIT_CLR,
                           target: STEP_SQR};
      STEP_MUL:      w = '{act: ACT_START_RB,  wb: WB_NONE,    cond: C_NEVER,
                           target: STEP_IDLE};
      STEP_MUL_WAIT: w = '{act: ACT_NONE,      wb: WB_R,       cond: C_BUSY,
                           target: STEP_MUL_WAIT};
      STEP_SQR:      w = '{act: ACT_START_BB,  wb: WB_NONE,    cond: C_NEVER,
                           target: STEP_IDLE};
      STEP_SQR_WAIT: w = '{act: ACT_NONE,      wb: WB_B_SHIFT, cond: C_BUSY,
                           target: STEP_SQR_WAIT};
      STEP_LOOP:     w = '{act: ACT_NONE,      wb: WB_NONE,    cond: C_ALWAYS,
                           target: STEP_TEST_E};
      STEP_OUT:      w = '{act: ACT_OUTPUT,    wb: WB_NONE,    cond: C_OUT_FULL,
                           target: STEP_OUT};
      default:       w = '{act: ACT_NONE,      wb: WB_NONE,    cond: C_ALWAYS,
                           target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/mexp_mulmod.sv */
module mexp_mulmod #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             busy,
  output logic [WIDTH-1:0] result
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] sh_r, sh_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  logic [WIDTH+1:0] t, q1, q2, t_m1, t_m2, pick;

  // One multiplier bit per cycle: 2*acc + bit*a stays below 3q, so at most
  // two multiples of q come off.
  always_comb begin
    q1   = {2'b00, modulus};
    q2   = {1'b0, modulus, 1'b0};
    t    = {1'b0, acc_r, 1'b0} + (sh_r[WIDTH-1] ? {2'b00, a_r} : '0);
    t_m1 = t - q1;
    t_m2 = t - q2;
    if (t >= q2) begin
      pick = t_m2;
    end else if (t >= q1) begin
      pick = t_m1;
    end else begin
      pick = t;
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      sh_nxt   = op_b;
      a_nxt    = op_a;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = pick[WIDTH-1:0];
      sh_nxt  = {sh_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    a_r   <= a_nxt;
  end

  assign busy   = busy_r;
  assign result = acc_r;

endmodule

/* sv/mexp_sequencer.sv */
module mexp_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mexp_pkg::status_t    status,
  output mexp_pkg::ctrl_word_t ctrl,
  output logic                 fire
);

  logic [mexp_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      cond_true;

  assign ctrl = mexp_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      mexp_pkg::C_NEVER:     cond_true = 1'b0;
      mexp_pkg::C_ALWAYS:    cond_true = 1'b1;
      mexp_pkg::C_NO_IN:     cond_true = !status.in_valid;
      mexp_pkg::C_Q_ONE:     cond_true = status.q_one;
      mexp_pkg::C_BUSY:      cond_true = status.busy;
      mexp_pkg::C_E_ZERO:    cond_true = status.e_zero;
      mexp_pkg::C_E_BIT_CLR: cond_true = !status.e_bit;
      mexp_pkg::C_OUT_FULL:  cond_true = status.out_full;
      default:               cond_true = 1'b1;
    endcase
  end

  assign fire   = !cond_true;
  assign pc_nxt = cond_true ? ctrl.target : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mexp_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* sv/modular_exponentiation_unit.sv */
// Channel   Direction  Handshake         Payload
// in        input      in_valid/stall    in_base_value, in_exponent
// out       output     out_valid/stall   out_power_result
// cfg       input      cfg_valid/ready   cfg_modulus
//
// One item at a time; each modular multiplication uses the shared bit-serial
// multiplier-reducer and two sequencer steps.
// With a modulus of one an item skips straight to the output.
// Reset is synchronous and leaves the modulus at one.
// A finished item waits in the output register while the next one is accepted.
module modular_exponentiation_unit #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_base_value,
  input  logic [WIDTH-1:0] in_exponent,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_power_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIDTH-1:0] cfg_modulus
);

  localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

  mexp_pkg::ctrl_word_t ctrl;
  mexp_pkg::status_t    status;
  logic                 fire;

  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a, mul_b, mul_result;
  logic             mul_busy;
  logic             in_accept;

  assign status.in_valid = in_valid;
  assign status.q_one    = (q_r == ONE);
  assign status.busy     = mul_busy;
  assign status.e_zero   = (e_r == '0);
  assign status.e_bit    = e_r[0];
  assign status.out_full = out_valid_r && out_stall;

  mexp_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .fire   (fire)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a     = b_r;
    mul_b     = b_r;
    case (ctrl.act)
      mexp_pkg::ACT_START_RED: begin
        mul_start = 1'b1;
        mul_a     = ONE;
      end
      mexp_pkg::ACT_START_RB: begin
        mul_start = 1'b1;
        mul_a     = r_r;
      end
      mexp_pkg::ACT_START_BB: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mexp_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (q_r),
    .busy    (mul_busy),
    .result  (mul_result)
  );

  assign in_stall  = (ctrl.act != mexp_pkg::ACT_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    q_nxt         = q_r;
    r_nxt         = r_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cfg_valid && (cfg_modulus != '0)) begin
      q_nxt = cfg_modulus;
    end
    if (in_accept) begin
      b_nxt = in_base_value;
      e_nxt = in_exponent;
      r_nxt = status.q_one ? '0 : ONE;
    end
    if (fire) begin
      case (ctrl.wb)
        mexp_pkg::WB_B: b_nxt = mul_result;
        mexp_pkg::WB_R: r_nxt = mul_result;
        mexp_pkg::WB_B_SHIFT: begin
          b_nxt = mul_result;
          e_nxt = {1'b0, e_r[WIDTH-1:1]};
        end
        default: b_nxt = b_nxt;
      endcase
      if (ctrl.act == mexp_pkg::ACT_OUTPUT) begin
        out_data_nxt  = r_r;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r         <= ONE;
      out_valid_r <= 1'b0;
    end else begin
      q_r         <= q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted but sequencer did not leave idle");

  a_result_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r < q_r))
    else $error("result not reduced below the modulus");

  a_busy_in_wait_step: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy |-> (ctrl.cond == mexp_pkg::C_BUSY))
    else $error("multiplier busy outside a wait step");

  a_q_one_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && status.q_one) |=> (r_r == '0))
    else $error("modulus of one did not clear the result");

endmodule

/* dv/modular_exponentiation_unit_tb.sv */
module modular_exponentiation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = mexp_pkg::WIDTH_DEF;
  localparam int STALL_LIMIT = 40000;
  localparam int PHASE_ITEMS = 115;
  localparam int RANDOM_PHASES = 10;
  localparam logic [WIDTH-1:0] NEAR_TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef struct packed {
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent;
  } pow_request_t;

  typedef struct packed {
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] power_result;
  } pow_check_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WIDTH-1:0] in_base_value = '0;
  logic [WIDTH-1:0] in_exponent = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WIDTH-1:0] out_power_result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIDTH-1:0] cfg_modulus = '0;

  pow_request_t     pow_requests_q[$];
  pow_check_t       expected_powers_q[$];
  logic [WIDTH-1:0] modulus_shadow = 1;
  int               fail_count = 0;
  int               idle_cycles = 0;
  int               in_gap = 0;
  int               out_wait = 0;
  bit               in_burst = 1'b0;
  bit               out_burst = 1'b0;
  pow_request_t     next_request;
  pow_check_t       oldest_power;

  modular_exponentiation_unit #(
    .WIDTH(WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_modulus      (cfg_modulus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WIDTH-1:0] mul_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] q);
    logic [2*WIDTH-1:0] product;
    product = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
    return WIDTH'(product % {{WIDTH{1'b0}}, q});
  endfunction

  function automatic logic [WIDTH-1:0] mod_pow(input logic [WIDTH-1:0] base_value,
                                               input logic [WIDTH-1:0] exponent,
                                               input logic [WIDTH-1:0] q);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] sq;
    if (q <= 1) begin
      return '0;
    end
    acc = 1;
    sq = base_value % q;
    for (int i = 0; i < WIDTH; i++) begin
      if (exponent[i]) begin
        acc = mul_mod(acc, sq, q);
      end
      sq = mul_mod(sq, sq, q);
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] rand_word();
    return WIDTH'({$urandom, $urandom});
  endfunction

  function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] q);
    logic [WIDTH-1:0] b;
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = 1;
      2: b = q - 1;
      3: b = q;
      4: b = '1;
      5: b = WIDTH'($urandom_range(0, 1000));
      default: b = rand_word();
    endcase
    return b;
  endfunction

  // Long exponents cost up to 129 multiplications, so most are kept short.
  function automatic logic [WIDTH-1:0] pick_exponent();
    logic [WIDTH-1:0] e;
    int len;
    case ($urandom_range(0, 99))
      0: e = rand_word();
      1: e = '1;
      2, 3: e = {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
      default: begin
        len = $urandom_range(0, 9);
        e = rand_word() & ~({WIDTH{1'b1}} << len);
      end
    endcase
    return e;
  endfunction

  task automatic add_item(input logic [WIDTH-1:0] base_value,
                          input logic [WIDTH-1:0] exponent);
    pow_requests_q.push_back('{base_value: base_value, exponent: exponent});
  endtask

  // Sampled at the falling edge, once the clocked blocks have settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pow_requests_q.size() != 0 || in_valid || expected_powers_q.size() != 0);
  endtask

  task automatic write_modulus(input logic [WIDTH-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_modulus <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    // A zero write leaves the register unchanged.
    if (value != 0) begin
      modulus_shadow = value;
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_powers_q.push_back('{base_value: in_base_value, exponent: in_exponent,
          power_result: mod_pow(in_base_value, in_exponent, modulus_shadow)});
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pow_requests_q.size() != 0) begin
          next_request = pow_requests_q.pop_front();
          in_valid <= 1'b1;
          in_base_value <= next_request.base_value;
          in_exponent <= next_request.exponent;
          if ($urandom_range(0, 31) == 0) begin
            in_burst = !in_burst;
          end
          in_gap <= in_burst ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_powers_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected item: power_result %h", out_power_result);
        end
      end else begin
        oldest_power = expected_powers_q.pop_front();
        if (out_power_result !== oldest_power.power_result) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch: base %h exponent %h: expected %h, got %h",
                     oldest_power.base_value, oldest_power.exponent,
                     oldest_power.power_result, out_power_result);
          end
        end
      end
      if ($urandom_range(0, 31) == 0) begin
        out_burst = !out_burst;
      end
      out_wait = out_burst ? 0 : $urandom_range(0, 4);
      out_stall <= (out_wait != 0);
    end else if (out_valid && out_wait != 0) begin
      out_wait = out_wait - 1;
      out_stall <= (out_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [WIDTH-1:0] q;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The modulus is one after reset, so every result is zero.
    add_item('0, '0);
    add_item('1, '1);
    add_item(12345, '0);
    add_item(7, 3);
    wait_drained();

    write_modulus('1);
    add_item('0, '0);
    add_item('1, 1);
    add_item('1 - 1, '1);
    add_item(2, 63);
    add_item(2, 64);
    add_item('0, 5);
    add_item('1, '0);
    wait_drained();

    write_modulus(2);
    add_item(3, {1'b1, {(WIDTH-1){1'b0}}});
    add_item(4, 7);
    wait_drained();

    write_modulus('0);
    add_item(3, 1);
    add_item(5, '0);
    wait_drained();

    write_modulus({1'b1, {(WIDTH-1){1'b0}}});
    add_item(3, 8'hFF);
    add_item({1'b1, {(WIDTH-4){1'b0}}, 3'd5}, 2);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: q = '1;
        1: q = NEAR_TOP_PRIME;
        2: q = rand_word() | {1'b1, {(WIDTH-1){1'b0}}};
        3: q = WIDTH'($urandom_range(2, 255));
        4: q = WIDTH'($urandom) | 1;
        5: q = 1;
        6: q = rand_word();
        7: q = '0;
        8: q = 3;
        default: q = rand_word();
      endcase
      write_modulus(q);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        add_item(pick_base(modulus_shadow), pick_exponent());
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_powers_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
